// File: src/fmprf_pkg.sv
// Package for the first-match packet rule filter.
// Holds the word types, the opcode codes and the token handed along the cell chain.
// No dependencies.
package fmprf_pkg;

    // Width of the reported rule index.
    localparam int HIT_IDX_W = 4;

    // Operation codes carried in the opcode field.
    typedef enum logic {
        OP_ADD      = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_opcode;

    // Input word: a rule to add or a packet header to classify.
    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        src_wild;
        logic        dst_wild;
        logic        permit;
    } t_in;

    // Result word.
    typedef struct packed {
        logic                 allowed;
        logic                 hit;
        logic [HIT_IDX_W-1:0] hit_index;
        logic                 add_rejected;
    } t_out;

    // Packet header fields compared against each rule.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_hdr;

    // Classify token passed from one cell to the next.
    typedef struct packed {
        logic                 valid;
        t_hdr                 hdr;
        logic                 found;
        logic                 allow;
        logic [HIT_IDX_W-1:0] idx;
    } t_token;

endpackage

// File: src/fmprf_cell.sv
// One rule cell of the first-match packet rule filter chain.
// Stores a single rule and forwards the classify token to its neighbor.
// Depends on fmprf_pkg.
module fmprf_cell #(
    parameter int K = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  fmprf_pkg::t_in      i_rule,
    input  logic                i_active,
    input  fmprf_pkg::t_token   i_tok,
    output fmprf_pkg::t_token   o_tok
);

    localparam logic [fmprf_pkg::HIT_IDX_W-1:0] CELL_IDX = fmprf_pkg::HIT_IDX_W'(K);

    // Rule storage; contents are meaningless until written.
    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic [15:0] r_src_port;
    logic [15:0] r_dst_port;
    logic        r_src_any;
    logic        r_dst_any;
    logic        r_allow;

    fmprf_pkg::t_token r_tok;
    fmprf_pkg::t_token n_tok;
    logic              w_match;

    // Rule write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_src_addr <= i_rule.src_ip;
            r_dst_addr <= i_rule.dst_ip;
            r_src_port <= i_rule.src_port;
            r_dst_port <= i_rule.dst_port;
            r_src_any  <= i_rule.src_wild;
            r_dst_any  <= i_rule.dst_wild;
            r_allow    <= i_rule.permit;
        end
    end

    // Compare the passing header against this rule; port 0 is a wildcard.
    always_comb begin
        w_match = (r_src_any || (r_src_addr == i_tok.hdr.src_ip)) &&
                  (r_dst_any || (r_dst_addr == i_tok.hdr.dst_ip)) &&
                  ((r_src_port == 16'd0) || (r_src_port == i_tok.hdr.src_port)) &&
                  ((r_dst_port == 16'd0) || (r_dst_port == i_tok.hdr.dst_port));
    end

    // The first matching cell claims the token; later cells leave it alone.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_active && !i_tok.found && w_match) begin
            n_tok.found = 1'b1;
            n_tok.allow = r_allow;
            n_tok.idx   = CELL_IDX;
        end
    end

    // Token register; reset drops any header in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: src/first_match_packet_rule_filter.sv
// Top level of the first-match packet rule filter.
// Instantiates a chain of fmprf_cell rule cells; depends on fmprf_pkg.
//
// Usage:
//   A word on i_in is taken at a rising edge where start is high and busy is low.
//   An add word (opcode OP_ADD) is written straight into the next free cell and
//   its result appears on o_out with o_strobe in the next cycle; busy stays low,
//   so a new word may follow in the very next cycle.
//   A classify word (opcode OP_CLASSIFY) walks the cell chain, one cell per
//   cycle, and the result register after the last cell strobes its result.
//   busy is high during the walk and drops as the result is strobed: the
//   chain carries one header at a time, so no new word is taken while busy is high.
//   Each result is shown for exactly one cycle; the receiver cannot stall it.
//   Rules are compared in insertion order; the first match decides allow or
//   deny, and no match means deny. An add to a full table is dropped and
//   flagged with add_rejected.
//   Reset (synchronous, active low) empties the table and clears busy and
//   any word in flight; no clearing pass is needed.
module first_match_packet_rule_filter #(
    parameter int MAX_RULES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  fmprf_pkg::t_in  i_in,
    output logic            o_strobe,
    output fmprf_pkg::t_out o_out
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_busy;
    logic              n_busy;
    logic              r_out_valid;
    logic              n_out_valid;
    fmprf_pkg::t_out   r_out;
    fmprf_pkg::t_out   n_out;

    logic              w_accept;
    logic              w_add;
    logic              w_full;
    fmprf_pkg::t_token w_tok [MAX_RULES+1];

    assign w_accept = start && !r_busy;
    assign w_add    = w_accept && (i_in.opcode == fmprf_pkg::OP_ADD);
    assign w_full   = (r_count >= CNT_W'(MAX_RULES));

    // Token entering the first cell.
    always_comb begin
        w_tok[0].valid = w_accept && (i_in.opcode == fmprf_pkg::OP_CLASSIFY);
        w_tok[0].hdr   = '{src_ip:   i_in.src_ip,
                           dst_ip:   i_in.dst_ip,
                           src_port: i_in.src_port,
                           dst_port: i_in.dst_port};
        w_tok[0].found = 1'b0;
        w_tok[0].allow = 1'b0;
        w_tok[0].idx   = '0;
    end

    // Rule cell chain.
    for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
        fmprf_cell #(
            .K (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_add && !w_full && (r_count == CNT_W'(k))),
            .i_rule   (i_in),
            .i_active (r_count > CNT_W'(k)),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    // Rule count, busy flag and the result register.
    always_comb begin
        n_count     = r_count;
        n_busy      = r_busy;
        n_out_valid = 1'b0;
        n_out       = r_out;
        if (w_add) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            if (w_full) begin
                n_out.add_rejected = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (w_accept) begin
            n_busy = 1'b1;
        end
        if (w_tok[MAX_RULES].valid) begin
            n_busy            = 1'b0;
            n_out_valid       = 1'b1;
            n_out.add_rejected = 1'b0;
            n_out.hit         = w_tok[MAX_RULES].found;
            n_out.allowed     = w_tok[MAX_RULES].found && w_tok[MAX_RULES].allow;
            n_out.hit_index   = w_tok[MAX_RULES].found ? w_tok[MAX_RULES].idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign busy     = r_busy;
    assign o_strobe = r_out_valid;
    assign o_out    = r_out;

endmodule

// File: src/fmprf_checker.sv
// Port-level checker for the first-match packet rule filter, with its bind.
// Depends on fmprf_pkg and first_match_packet_rule_filter.
module fmprf_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input fmprf_pkg::t_in  i_in,
    input logic            o_strobe,
    input fmprf_pkg::t_out o_out
);

    // A taken classify word holds the block busy.
    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_in.opcode == fmprf_pkg::OP_CLASSIFY) |=> busy)
        else $error("classify word taken but busy not raised");

    // A taken add word answers in the next cycle.
    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_in.opcode == fmprf_pkg::OP_ADD) |=> o_strobe)
        else $error("add word without a result in the next cycle");

    // Busy only falls when the classify result is shown.
    a_busy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // A result without a hit reports index zero and deny.
    a_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out.hit |-> (o_out.hit_index == '0) && !o_out.allowed)
        else $error("miss result carries index or allow");

    // A result with a hit never flags a rejected add.
    a_hit_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.hit |-> !o_out.add_rejected)
        else $error("hit result flags a rejected add");

endmodule

bind first_match_packet_rule_filter fmprf_checker u_fmprf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_strobe (o_strobe),
    .o_out    (o_out)
);
